// ----- src/rsat_pkg.sv -----
// Package for the reliable sequence ack tracker.
// Holds the item kinds, event codes, controller states and command/status structs.
// No dependencies.
`default_nettype none
package rsat_pkg;
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_RECV = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [2:0] EV_HEADER = 3'd0;
    localparam logic [2:0] EV_RECEIVED = 3'd1;
    localparam logic [2:0] EV_RESEND = 3'd2;
    localparam logic [2:0] EV_GAVE_UP = 3'd3;
    localparam logic [2:0] EV_IDLE = 3'd4;
    localparam logic [2:0] EV_FULL = 3'd5;
    localparam logic [2:0] EV_OUT_WIN = 3'd6;

    localparam logic CFG_RESEND = 1'b0;
    localparam logic CFG_RETRIES = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEND_SCAN,
        S_SEND_DONE,
        S_RECV_SCAN,
        S_RECV_MARK,
        S_RECV_ADV,
        S_RECV_DONE,
        S_TICK_SCAN,
        S_TICK_DONE,
        S_OTHER
    } t_state;

    typedef struct packed {
        logic latch;
        logic send_scan;
        logic send_commit;
        logic recv_scan;
        logic recv_mark;
        logic recv_adv;
        logic recv_out;
        logic tick_scan;
        logic tick_idle;
        logic idle_out;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic adv_end;
        logic tick_end;
        logic [1:0] kind;
    } t_status;
endpackage
`default_nettype wire

// ----- src/rsat_ctrl.sv -----
// Controller state machine of the reliable sequence ack tracker.
// Depends on rsat_pkg.
`default_nettype none
module rsat_ctrl import rsat_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_stat,
    output t_cmd         o_cmd,
    output logic         o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_stat.kind)
                        KIND_SEND: n_state = S_SEND_SCAN;
                        KIND_RECV: n_state = S_RECV_SCAN;
                        KIND_TICK: n_state = S_TICK_SCAN;
                        default:   n_state = S_OTHER;
                    endcase
                end
            end
            S_SEND_SCAN: if (i_stat.scan_end) n_state = S_SEND_DONE;
            S_SEND_DONE: n_state = S_IDLE;
            S_RECV_SCAN: if (i_stat.scan_end) n_state = S_RECV_MARK;
            S_RECV_MARK: n_state = S_RECV_ADV;
            S_RECV_ADV:  if (i_stat.adv_end) n_state = S_RECV_DONE;
            S_RECV_DONE: n_state = S_IDLE;
            S_TICK_SCAN: if (i_stat.tick_end) n_state = S_TICK_DONE;
            S_TICK_DONE: n_state = S_IDLE;
            S_OTHER:     n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:      o_cmd.latch = i_start;
            S_SEND_SCAN: o_cmd.send_scan = 1'b1;
            S_SEND_DONE: o_cmd.send_commit = 1'b1;
            S_RECV_SCAN: o_cmd.recv_scan = 1'b1;
            S_RECV_MARK: o_cmd.recv_mark = 1'b1;
            S_RECV_ADV:  o_cmd.recv_adv = 1'b1;
            S_RECV_DONE: o_cmd.recv_out = 1'b1;
            S_TICK_SCAN: o_cmd.tick_scan = 1'b1;
            S_TICK_DONE: o_cmd.tick_idle = 1'b1;
            S_OTHER:     o_cmd.idle_out = 1'b1;
            default:     o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ----- src/rsat_dp.sv -----
// Datapath of the reliable sequence ack tracker: pending slots, receive window, counters.
// Depends on rsat_pkg; driven by rsat_ctrl.
`default_nettype none
module rsat_dp import rsat_pkg::*; #(
    parameter int WINDOW = 256,
    parameter int PENDING_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_stat,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_reliable,
    input  wire logic [31:0] i_rx_seq,
    input  wire logic [31:0] i_rx_ack,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    output logic [2:0]       o_event_res,
    output logic [31:0]      o_seq_value,
    output logic [31:0]      o_ack_value,
    output logic [31:0]      o_rtt_ticks,
    output logic             o_rtt_valid,
    output logic             o_last
);
    localparam int SW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int WW = $clog2(WINDOW);
    localparam int CW = $clog2(PENDING_SLOTS + 1);
    localparam logic [31:0] WIN32 = 32'(WINDOW);

    logic [15:0] r_resend;
    logic [7:0]  r_retries;
    logic        r_rel;
    logic [31:0] r_seq, r_ack;
    logic [31:0] r_next_out, r_contig, r_now;
    logic [WINDOW-1:0] r_win;
    logic [PENDING_SLOTS-1:0] r_sv;
    logic [31:0] r_sseq [PENDING_SLOTS];
    logic [31:0] r_sfirst [PENDING_SLOTS];
    logic [31:0] r_slast [PENDING_SLOTS];
    logic [7:0]  r_satt [PENDING_SLOTS];
    logic [CW-1:0] r_idx;
    logic [SW:0]   r_nres;
    logic        r_hit, r_free;
    logic [SW-1:0] r_hit_i, r_free_i;
    logic        r_any;
    logic [31:0] r_rtt;
    logic        r_drop;

    logic [SW-1:0] w_i;
    logic [31:0] w_el, w_since, w_diff;
    logic [WW-1:0] w_nidx;

    assign w_i = r_idx[SW-1:0];
    assign w_el = r_now - r_sfirst[w_i];
    assign w_since = r_now - r_slast[w_i];
    assign w_diff = r_seq - r_contig;
    assign w_nidx = WW'(r_contig + 32'd1);
    assign o_stat.kind = i_kind;
    assign o_stat.scan_end = (r_idx == CW'(PENDING_SLOTS - 1));
    assign o_stat.adv_end = (r_contig == 32'hFFFF_FFFF) || !r_win[w_nidx] || r_drop;
    assign o_stat.tick_end = (r_idx == CW'(PENDING_SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resend <= 16'd10;
            r_retries <= 8'd10;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_RESEND) r_resend <= i_cfg_data;
            else r_retries <= i_cfg_data[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_out <= '0;
            r_contig <= '0;
            r_now <= '0;
            r_win <= '0;
            r_sv <= '0;
            r_idx <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cmd.latch) begin
                r_rel <= i_reliable;
                r_seq <= i_rx_seq;
                r_ack <= i_rx_ack;
                r_idx <= '0;
                r_nres <= '0;
                r_hit <= 1'b0;
                r_free <= 1'b0;
                r_any <= 1'b0;
                r_rtt <= '0;
                r_drop <= 1'b0;
                if (i_kind == KIND_TICK) r_now <= r_now + 32'd1;
            end
            if (i_cmd.send_scan || i_cmd.recv_scan) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.send_scan && r_sv[w_i]) begin
                if (r_sseq[w_i] == r_next_out && !r_hit) begin
                    r_hit <= 1'b1;
                    r_hit_i <= w_i;
                end
            end
            if (i_cmd.send_scan && !r_sv[w_i] && !r_free) begin
                r_free <= 1'b1;
                r_free_i <= w_i;
            end
            if (i_cmd.send_commit) begin
                r_next_out <= r_next_out + 32'd1;
                if (r_rel && (r_hit || r_free)) begin
                    r_sv[r_hit ? r_hit_i : r_free_i] <= 1'b1;
                    r_sseq[r_hit ? r_hit_i : r_free_i] <= r_next_out;
                    r_sfirst[r_hit ? r_hit_i : r_free_i] <= r_now;
                    r_slast[r_hit ? r_hit_i : r_free_i] <= r_now;
                    r_satt[r_hit ? r_hit_i : r_free_i] <= 8'd1;
                end
                o_valid <= 1'b1;
                o_event_res <= (r_rel && !(r_hit || r_free)) ? EV_FULL : EV_HEADER;
                o_seq_value <= r_next_out;
                o_ack_value <= r_contig;
                o_rtt_ticks <= '0;
                o_rtt_valid <= 1'b0;
                o_last <= 1'b1;
            end
            if (i_cmd.recv_scan && r_sv[w_i] && r_sseq[w_i] <= r_ack) begin
                r_sv[w_i] <= 1'b0;
                r_any <= 1'b1;
                if (!r_any || w_el < r_rtt) r_rtt <= w_el;
            end
            if (i_cmd.recv_mark) begin
                if (r_seq == 32'd0 || r_seq <= r_contig) begin
                    r_drop <= 1'b1;
                end else if (w_diff > WIN32) begin
                    r_drop <= 1'b1;
                    r_nres[0] <= 1'b1;
                end else begin
                    r_win[WW'(r_seq)] <= 1'b1;
                end
            end
            if (i_cmd.recv_adv && !o_stat.adv_end) begin
                r_win[w_nidx] <= 1'b0;
                r_contig <= r_contig + 32'd1;
            end
            if (i_cmd.recv_out) begin
                o_valid <= 1'b1;
                o_event_res <= r_nres[0] ? EV_OUT_WIN : EV_RECEIVED;
                o_seq_value <= r_seq;
                o_ack_value <= r_contig;
                o_rtt_ticks <= r_rtt;
                o_rtt_valid <= r_any;
                o_last <= 1'b1;
            end
            if (i_cmd.tick_scan) begin
                r_idx <= r_idx + CW'(1);
                if (!o_stat.tick_end && r_sv[w_i] && w_since >= 32'(r_resend)) begin
                    r_nres <= r_nres + (SW+1)'(1);
                    o_valid <= 1'b1;
                    o_seq_value <= r_sseq[w_i];
                    o_ack_value <= r_contig;
                    o_rtt_ticks <= '0;
                    o_rtt_valid <= 1'b0;
                    o_last <= 1'b0;
                    if (r_satt[w_i] >= r_retries) begin
                        r_sv[w_i] <= 1'b0;
                        o_event_res <= EV_GAVE_UP;
                    end else begin
                        r_slast[w_i] <= r_now;
                        r_satt[w_i] <= r_satt[w_i] + 8'd1;
                        o_event_res <= EV_RESEND;
                    end
                end
            end
            if (i_cmd.tick_idle || i_cmd.idle_out) begin
                if (i_cmd.idle_out || r_nres == '0) begin
                    o_valid <= 1'b1;
                    o_event_res <= EV_IDLE;
                    o_seq_value <= '0;
                    o_ack_value <= r_contig;
                    o_rtt_ticks <= '0;
                    o_rtt_valid <= 1'b0;
                    o_last <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/reliable_sequence_ack_tracker_unit.sv -----
// Top level of the reliable sequence ack tracker: controller plus datapath.
// Depends on rsat_pkg, rsat_ctrl and rsat_dp.
// A new transaction is accepted only once busy has fallen after the previous one. A
// send, receive or tick scans the pending table one slot per cycle, and a receive then
// advances its window one position per cycle. Results appear with o_valid for one
// cycle each and cannot be stalled; the last one of an item carries o_last. A tick that
// resends or gives up slots adds no closing result: o_last rides on its final resend or
// give-up, and only a tick with none of them reports one idle result.
`default_nettype none
module reliable_sequence_ack_tracker_unit import rsat_pkg::*; #(
    parameter int WINDOW = 256,
    parameter int PENDING_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_reliable,
    input  wire logic [31:0] i_rx_seq,
    input  wire logic [31:0] i_rx_ack,
    output logic             o_valid,
    output logic [2:0]       o_event_res,
    output logic [31:0]      o_seq_value,
    output logic [31:0]      o_ack_value,
    output logic [31:0]      o_rtt_ticks,
    output logic             o_rtt_valid,
    output logic             o_last
);
    t_cmd    w_cmd;
    t_status w_stat;
    logic    w_busy;
    logic    w_valid, w_last;
    logic    r_hold;
    logic [2:0] w_ev;
    logic [31:0] w_seq, w_ack, w_rtt;
    logic    w_rttv;

    rsat_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(w_busy)
    );

    rsat_dp #(.WINDOW(WINDOW), .PENDING_SLOTS(PENDING_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_kind(i_kind), .i_reliable(i_reliable), .i_rx_seq(i_rx_seq),
        .i_rx_ack(i_rx_ack), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index[0]),
        .i_cfg_data(i_cfg_data), .o_valid(w_valid), .o_event_res(w_ev),
        .o_seq_value(w_seq), .o_ack_value(w_ack), .o_rtt_ticks(w_rtt),
        .o_rtt_valid(w_rttv), .o_last(w_last)
    );

    // All results are delayed one stage so the final tick result can carry the last mark.
    logic        r_pv, r_pl;
    logic [2:0]  r_pev;
    logic [31:0] r_pseq, r_pack, r_prtt;
    logic        r_prv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_hold <= 1'b0;
        end else begin
            if (w_valid) begin
                r_pv <= 1'b1;
                r_pl <= w_last;
                r_pev <= w_ev;
                r_pseq <= w_seq;
                r_pack <= w_ack;
                r_prtt <= w_rtt;
                r_prv <= w_rttv;
            end else if (r_pv && (r_pl || w_cmd.tick_idle)) begin
                r_pv <= 1'b0;
            end
            r_hold <= r_pv && !r_pl && !w_valid && !w_cmd.tick_idle;
        end
    end

    always_comb begin
        o_valid = r_pv && (w_valid || r_pl || w_cmd.tick_idle);
        o_last = r_pl || (w_cmd.tick_idle && !w_valid);
        o_event_res = r_pev;
        o_seq_value = r_pseq;
        o_ack_value = r_pack;
        o_rtt_ticks = r_prtt;
        o_rtt_valid = r_prv;
        busy = w_busy || r_pv || r_hold;
    end
endmodule
`default_nettype wire

// ----- src/rsat_checker.sv -----
// Port-level checker for the reliable sequence ack tracker, with its bind.
// Depends on reliable_sequence_ack_tracker_unit.
`default_nettype none
module rsat_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic       o_last,
    input wire logic [2:0] o_event_res
);
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !busy)
        else $error("activity after reset");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted transaction not busy");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid) else $error("result after last");
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_event_res != 3'd7) else $error("bad event code");
endmodule

bind reliable_sequence_ack_tracker_unit rsat_checker u_rsat_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_last(o_last), .o_event_res(o_event_res)
);
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for reliable_sequence_ack_tracker_unit.
// Runs a directed table and then random phases under several retry settings.
// Every result transaction is checked against an in-bench model of the tracker.
// Depends on rsat_pkg and the tracker RTL.
`default_nettype none
module tb;
    import rsat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam int SLOTS = 16;
    localparam int WIN = 256;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 47;

    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] rtt;
        logic        rtt_ok;
        logic        last;
    } t_outcome;

    typedef struct packed {
        logic [1:0]  kind;
        logic        rel;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [4:0]  reps;
        logic        typed;
        logic [2:0]  ev;
        logic [31:0] want_seq;
        logic [31:0] want_ack;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic [1:0]  i_kind = '0;
    logic        i_reliable = 1'b0;
    logic [31:0] i_rx_seq = '0;
    logic [31:0] i_rx_ack = '0;
    logic        o_valid;
    logic [2:0]  o_event_res;
    logic [31:0] o_seq_value;
    logic [31:0] o_ack_value;
    logic [31:0] o_rtt_ticks;
    logic        o_rtt_valid;
    logic        o_last;

    reliable_sequence_ack_tracker_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_kind(i_kind), .i_reliable(i_reliable), .i_rx_seq(i_rx_seq),
        .i_rx_ack(i_rx_ack), .o_valid(o_valid), .o_event_res(o_event_res),
        .o_seq_value(o_seq_value), .o_ack_value(o_ack_value),
        .o_rtt_ticks(o_rtt_ticks), .o_rtt_valid(o_rtt_valid), .o_last(o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Tracker state as the bench sees it.
    logic [15:0] resend_after;
    logic [7:0]  retry_cap;
    logic [31:0] out_seq;
    logic [31:0] contig;
    logic [31:0] clock_ticks;
    logic        seen_bits [WIN];
    logic        pend_valid [SLOTS];
    logic [31:0] pend_seq [SLOTS];
    logic [31:0] pend_first [SLOTS];
    logic [31:0] pend_last [SLOTS];
    logic [7:0]  pend_tries [SLOTS];

    t_outcome expected_results[$];
    int mismatches = 0;
    int stall_cycles = 0;
    int items_sent = 0;

    task automatic track_item(input logic [1:0] k, input logic rel,
                              input logic [31:0] sq, input logic [31:0] ak);
        t_outcome r;
        int i;
        int pick;
        int n;
        logic [31:0] el;
        logic [31:0] nxt;
        logic any;
        r = '0;
        case (k)
            KIND_SEND: begin
                r.seq = out_seq;
                r.ev = EV_HEADER;
                out_seq = out_seq + 32'd1;
                if (rel) begin
                    pick = -1;
                    for (i = 0; i < SLOTS; i++)
                        if (pick < 0 && pend_valid[i] && pend_seq[i] == r.seq) pick = i;
                    for (i = 0; i < SLOTS; i++)
                        if (pick < 0 && !pend_valid[i]) pick = i;
                    if (pick < 0) begin
                        r.ev = EV_FULL;
                    end else begin
                        pend_valid[pick] = 1'b1;
                        pend_seq[pick] = r.seq;
                        pend_first[pick] = clock_ticks;
                        pend_last[pick] = clock_ticks;
                        pend_tries[pick] = 8'd1;
                    end
                end
                r.ack = contig;
                expected_results.push_back(r);
            end
            KIND_RECV: begin
                any = 1'b0;
                r.ev = EV_RECEIVED;
                r.seq = sq;
                for (i = 0; i < SLOTS; i++) begin
                    if (pend_valid[i] && pend_seq[i] <= ak) begin
                        el = clock_ticks - pend_first[i];
                        if (!any || el < r.rtt) r.rtt = el;
                        any = 1'b1;
                        pend_valid[i] = 1'b0;
                    end
                end
                r.rtt_ok = any;
                if (sq != 32'd0 && sq > contig) begin
                    if (sq - contig > WIN) begin
                        r.ev = EV_OUT_WIN;
                    end else begin
                        seen_bits[sq[7:0]] = 1'b1;
                        while (contig != 32'hFFFF_FFFF) begin
                            nxt = contig + 32'd1;
                            if (!seen_bits[nxt[7:0]]) break;
                            seen_bits[nxt[7:0]] = 1'b0;
                            contig = nxt;
                        end
                    end
                end
                r.ack = contig;
                expected_results.push_back(r);
            end
            KIND_TICK: begin
                n = 0;
                clock_ticks = clock_ticks + 32'd1;
                for (i = 0; i < SLOTS && n < 16; i++) begin
                    if (pend_valid[i] && clock_ticks - pend_last[i] >= resend_after) begin
                        r = '0;
                        r.seq = pend_seq[i];
                        r.ack = contig;
                        if (pend_tries[i] >= retry_cap) begin
                            pend_valid[i] = 1'b0;
                            r.ev = EV_GAVE_UP;
                        end else begin
                            pend_last[i] = clock_ticks;
                            pend_tries[i] = pend_tries[i] + 8'd1;
                            r.ev = EV_RESEND;
                        end
                        expected_results.push_back(r);
                        n++;
                    end
                end
                if (n == 0) begin
                    r = '0;
                    r.ev = EV_IDLE;
                    r.ack = contig;
                    expected_results.push_back(r);
                end
            end
            default: begin
                r.ev = EV_IDLE;
                r.ack = contig;
                expected_results.push_back(r);
            end
        endcase
        expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    // Leaves start high after acceptance so back-to-back transactions need no lowering.
    task automatic issue_item(input logic [1:0] k, input logic rel,
                              input logic [31:0] sq, input logic [31:0] ak);
        int pct;
        pct = (items_sent < 77) ? 37 : (items_sent < 154) ? 49 : 0;
        while ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= k;
        i_reliable <= rel;
        i_rx_seq <= sq;
        i_rx_ack <= ak;
        do @(posedge i_clk); while (busy);
        track_item(k, rel, sq, ak);
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RESEND) resend_after = val;
        else retry_cap = val[7:0];
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int pick;
        int sel;
        logic [31:0] sq;
        logic [31:0] ak;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            issue_item(KIND_SEND, $urandom_range(0, 99) < 70, $urandom(), $urandom());
        end else if (pick < 68) begin
            issue_item(KIND_TICK, 1'($urandom_range(0, 1)), $urandom(), $urandom());
        end else if (pick < 95) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) sq = contig + $urandom_range(1, 12);
            else if (sel < 70) sq = contig - $urandom_range(0, 3);
            else if (sel < 80) sq = contig + $urandom_range(200, 300);
            else sq = $urandom();
            sel = $urandom_range(0, 99);
            if (sel < 70) ak = $urandom_range(0, out_seq);
            else if (sel < 85) ak = 32'd0;
            else ak = $urandom();
            issue_item(KIND_RECV, 1'($urandom_range(0, 1)), sq, ak);
        end else begin
            issue_item(KIND_OTHER, 1'($urandom_range(0, 1)), $urandom(), $urandom());
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_valid) begin
            got = '{o_event_res, o_seq_value, o_ack_value, o_rtt_ticks, o_rtt_valid, o_last};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    t_stim_row directed_rows[16] = '{
        '{KIND_SEND, 1'b0, 32'd0, 32'd0, 5'd1, 1'b1, EV_HEADER, 32'd0, 32'd0},
        '{KIND_OTHER, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b1, EV_IDLE, 32'd0, 32'd0},
        '{KIND_TICK, 1'b0, 32'd0, 32'd0, 5'd1, 1'b1, EV_IDLE, 32'd0, 32'd0},
        '{KIND_RECV, 1'b0, 32'd0, 32'd0, 5'd1, 1'b1, EV_RECEIVED, 32'd0, 32'd0},
        '{KIND_RECV, 1'b0, 32'd300, 32'd0, 5'd1, 1'b1, EV_OUT_WIN, 32'd300, 32'd0},
        '{KIND_RECV, 1'b0, 32'd1, 32'd0, 5'd1, 1'b1, EV_RECEIVED, 32'd1, 32'd1},
        '{KIND_RECV, 1'b0, 32'd1, 32'd0, 5'd1, 1'b1, EV_RECEIVED, 32'd1, 32'd1},
        '{KIND_RECV, 1'b0, 32'd3, 32'd0, 5'd1, 1'b1, EV_RECEIVED, 32'd3, 32'd1},
        '{KIND_RECV, 1'b0, 32'd2, 32'd0, 5'd1, 1'b1, EV_RECEIVED, 32'd2, 32'd3},
        '{KIND_RECV, 1'b0, 32'd259, 32'd0, 5'd1, 1'b1, EV_RECEIVED, 32'd259, 32'd3},
        '{KIND_RECV, 1'b0, 32'd260, 32'd0, 5'd1, 1'b1, EV_OUT_WIN, 32'd260, 32'd3},
        '{KIND_RECV, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b1, EV_OUT_WIN,
          32'hFFFF_FFFF, 32'd3},
        '{KIND_SEND, 1'b1, 32'd0, 32'd0, 5'd17, 1'b0, EV_HEADER, 32'd0, 32'd0},
        '{KIND_TICK, 1'b0, 32'd0, 32'd0, 5'd12, 1'b0, EV_IDLE, 32'd0, 32'd0},
        '{KIND_RECV, 1'b1, 32'd4, 32'd5, 5'd1, 1'b0, EV_RECEIVED, 32'd0, 32'd0},
        '{KIND_RECV, 1'b0, 32'd0, 32'hFFFF_FFFF, 5'd1, 1'b0, EV_RECEIVED, 32'd0, 32'd0}
    };

    logic [15:0] resend_plan [4] = '{16'd0, 16'd65535, 16'd1, 16'd3};
    logic [15:0] retry_plan [4] = '{16'd0, 16'd255, 16'd1, 16'd4};

    initial begin
        resend_after = 16'd10;
        retry_cap = 8'd10;
        out_seq = '0;
        contig = '0;
        clock_ticks = '0;
        for (int i = 0; i < WIN; i++) seen_bits[i] = 1'b0;
        for (int i = 0; i < SLOTS; i++) pend_valid[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (directed_rows[r]) begin
            for (int j = 0; j < directed_rows[r].reps; j++) begin
                issue_item(directed_rows[r].kind, directed_rows[r].rel,
                           directed_rows[r].seq, directed_rows[r].ack);
                if (directed_rows[r].typed) begin
                    expected_results[$].ev = directed_rows[r].ev;
                    expected_results[$].seq = directed_rows[r].want_seq;
                    expected_results[$].ack = directed_rows[r].want_ack;
                end
            end
        end

        for (int p = 0; p < 4; p++) begin
            drain_results();
            write_reg(CFG_RESEND, resend_plan[p]);
            write_reg(CFG_RETRIES, retry_plan[p]);
            for (int j = 0; j < ITEMS_PER_PHASE; j++) random_item();
        end

        drain_results();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
